[hdl/mocap_pose_decimate_differentiate_macros.svh]
// ============================================================================
// mocap_pose_decimate_differentiate_macros.svh
// Assertion macros shared by the pose decimator RTL.
// ============================================================================
`ifndef MOCAP_POSE_DECIMATE_DIFFERENTIATE_MACROS_SVH
`define MOCAP_POSE_DECIMATE_DIFFERENTIATE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define MPD_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MPD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/mpd_pkg.sv]
// ============================================================================
// mpd_pkg
// Shared widths, register codes, reset values and the MAC operation type.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package mpd_pkg;

    localparam int POS_W      = 32;
    localparam int Q_W        = 16;
    localparam int STAMP_W    = 63;
    localparam int SEQ_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam int MAC_A_W    = 36;
    localparam int MAC_B_W    = 25;
    localparam int MAC_P_W    = MAC_A_W + MAC_B_W;
    localparam int ACC_W      = 64;
    localparam int HI_SHIFT   = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLES_PER_OUTPUT = 2'd0,
        CFG_INV_SAMPLES        = 2'd1,
        CFG_INV_OUTPUT_PERIOD  = 2'd2,
        CFG_HOLD_STEP          = 2'd3
    } cfg_reg_t;

    localparam logic [7:0]  SPO_RST    = 8'd1;
    localparam logic [16:0] INV_S_RST  = 17'd65536;
    localparam logic [23:0] INV_P_RST  = 24'd25600;
    localparam logic [23:0] HOLD_RST   = 24'd167772;
    localparam logic signed [Q_W-1:0] Q_ONE = 16'sd16384;
    localparam logic signed [ACC_W-1:0] ROT_HALF = 64'sd134217728;

    typedef struct packed {
        logic                      vld;
        logic                      hi;
        logic                      first;
        logic signed [ACC_W-1:0]   init;
        logic signed [MAC_A_W-1:0] a;
        logic signed [MAC_B_W-1:0] b;
    } mac_op_t;

endpackage

`default_nettype wire

[hdl/mpd_cfg_if.sv]
// ============================================================================
// mpd_cfg_if
// Register write channel: index and data with valid/ready.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface mpd_cfg_if import mpd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hdl/mpd_in_if.sv]
// ============================================================================
// mpd_in_if
// Pose sample channel with valid/ready.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface mpd_in_if import mpd_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    occluded;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [Q_W-1:0]   quat_w;
    logic signed [Q_W-1:0]   quat_x;
    logic signed [Q_W-1:0]   quat_y;
    logic signed [Q_W-1:0]   quat_z;
    logic [STAMP_W-1:0]      stamp_us;
    logic [SEQ_W-1:0]        sequence_req;

    modport source (output valid, occluded, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y,
                    quat_z, stamp_us, sequence_req, input ready);
    modport sink   (input valid, occluded, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y,
                    quat_z, stamp_us, sequence_req, output ready);
endinterface

`default_nettype wire

[hdl/mpd_out_if.sv]
// ============================================================================
// mpd_out_if
// Decimated pose and twist channel with valid/ready.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface mpd_out_if import mpd_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [SEQ_W-1:0]        out_sequence;
    logic [STAMP_W-1:0]      out_stamp_us;
    logic signed [POS_W-1:0] avg_x;
    logic signed [POS_W-1:0] avg_y;
    logic signed [POS_W-1:0] avg_z;
    logic [4*Q_W-1:0]        orientation;
    logic signed [POS_W-1:0] vel_x;
    logic signed [POS_W-1:0] vel_y;
    logic signed [POS_W-1:0] vel_z;
    logic signed [POS_W-1:0] rate_x;
    logic signed [POS_W-1:0] rate_y;
    logic signed [POS_W-1:0] rate_z;

    modport source (output valid, out_sequence, out_stamp_us, avg_x, avg_y, avg_z,
                    orientation, vel_x, vel_y, vel_z, rate_x, rate_y, rate_z, input ready);
    modport sink   (input valid, out_sequence, out_stamp_us, avg_x, avg_y, avg_z,
                    orientation, vel_x, vel_y, vel_z, rate_x, rate_y, rate_z, output ready);
endinterface

`default_nettype wire

[hdl/mpd_mac.sv]
// ============================================================================
// mpd_mac
// Shared two-stage multiply-accumulate: registered product, then accumulate.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module mpd_mac import mpd_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire mac_op_t                 op,
    output logic signed [ACC_W-1:0]      acc
);

    logic                      vld_reg;
    logic                      hi_reg;
    logic                      first_reg;
    logic signed [MAC_P_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]   init_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [ACC_W-1:0]   addend;
    logic signed [ACC_W-1:0]   base;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= 1'b0;
            hi_reg    <= 1'b0;
            first_reg <= 1'b0;
        end
        else
        begin
            vld_reg   <= op.vld;
            hi_reg    <= op.hi;
            first_reg <= op.first;
        end
    end

    always_comb
    begin
        prod_ext = {{(ACC_W-MAC_P_W){prod_reg[MAC_P_W-1]}}, prod_reg};
        if (!vld_reg)
            addend = '0;
        else if (hi_reg)
            addend = prod_ext <<< HI_SHIFT;
        else
            addend = prod_ext;
        base = first_reg ? init_reg : acc_reg;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= $signed(op.a) * $signed(op.b);
        init_reg <= op.init;
        acc_reg  <= base + addend;
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

[hdl/mocap_pose_decimate_differentiate.sv]
// ============================================================================
// mocap_pose_decimate_differentiate
// Pose decimator: occlusion hold, boxcar mean, finite-difference twist.
// ============================================================================
// Usage:
//  cfg    : register writes (index, data); always ready. Write only when idle.
//  sample : one pose per beat; ready only while the sequencer is idle.
//  result : one beat per samples_per_output samples, held in an output
//           register until taken; the next sample is accepted meanwhile.
// Jobs (one shared 36x25 MAC; each job issues its ops, then passes WAIT and WRITE):
//  plain sample, no result       : merge only
//  occluded sample               : three extrapolation jobs before the merge
//  batch end, twist held         : three mean jobs, nine rotation matrix jobs
//  batch end, twist recomputed   : also three velocity jobs, three skew/rate pairs
// A finished result waits in DONE if the previous beat is still unclaimed,
// so a stalled receiver eventually holds off the sample channel.
// Reset: registers to defaults, held pose to origin/identity, empty batch,
// no stamp seen. No clearing pass.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
`include "mocap_pose_decimate_differentiate_macros.svh"

module mocap_pose_decimate_differentiate import mpd_pkg::*;
#(
    parameter int MAX_SAMPLES = 255
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    mpd_cfg_if.sink    cfg,
    mpd_in_if.sink     sample,
    mpd_out_if.source  result
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam logic [1:0] QW = 2'd0;
    localparam logic [1:0] QX = 2'd1;
    localparam logic [1:0] QY = 2'd2;
    localparam logic [1:0] QZ = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE, S_ISSUE, S_WAIT, S_WRITE, S_MERGE, S_DONE
    } state_t;

    typedef enum logic [4:0] {
        J_EXT0, J_EXT1, J_EXT2,
        J_MEAN0, J_MEAN1, J_MEAN2,
        J_ROT0, J_ROT1, J_ROT2, J_ROT3, J_ROT4, J_ROT5, J_ROT6, J_ROT7, J_ROT8,
        J_VEL0, J_VEL1, J_VEL2,
        J_SKEW0, J_RATE0, J_SKEW1, J_RATE1, J_SKEW2, J_RATE2
    } job_t;

    typedef struct packed {
        logic [1:0] fa;
        logic [1:0] fb;
        logic       neg;
    } rot_term_t;

    // config
    logic [7:0]  spo_reg;
    logic [16:0] inv_s_reg;
    logic [23:0] inv_p_reg;
    logic [23:0] hold_reg;

    // control and held state
    state_t      state_reg;
    job_t        job_reg;
    logic [2:0]  op_idx_reg;
    logic        upd_reg;
    logic        occ_reg;
    logic        seen_reg;
    logic [STAMP_W-1:0] prev_stamp_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic        out_vld_reg;
    logic signed [POS_W-1:0] held_pos_reg  [3];
    logic signed [Q_W-1:0]   held_q_reg    [4];
    logic signed [POS_W-1:0] held_vel_reg  [3];
    logic signed [POS_W-1:0] held_rate_reg [3];
    logic signed [39:0]      sum_reg       [3];
    logic signed [POS_W-1:0] prev_mean_reg [3];
    logic signed [Q_W-1:0]   prev_rot_reg  [9];

    // working payload
    logic signed [POS_W-1:0] cur_pos_reg [3];
    logic signed [Q_W-1:0]   cur_q_reg   [4];
    logic [STAMP_W-1:0]      stamp_reg;
    logic [SEQ_W-1:0]        seq_reg;
    logic signed [POS_W-1:0] mean_reg [3];
    logic signed [Q_W-1:0]   rot_reg  [9];
    logic signed [MAC_A_W-1:0] skew_reg;

    // output payload
    logic [SEQ_W-1:0]        o_seq_reg;
    logic [STAMP_W-1:0]      o_stamp_reg;
    logic signed [POS_W-1:0] o_avg_reg  [3];
    logic [4*Q_W-1:0]        o_quat_reg;
    logic signed [POS_W-1:0] o_vel_reg  [3];
    logic signed [POS_W-1:0] o_rate_reg [3];

    // decode
    mac_op_t     mac_op;
    logic signed [ACC_W-1:0] acc;
    logic [2:0]  last_idx;
    logic [4:0]  rnd_sh;
    logic [1:0]  ax;
    logic [3:0]  ent;
    logic [1:0]  k;
    logic [1:0]  row_a;
    logic [1:0]  row_b;
    logic [3:0]  ia;
    logic [3:0]  ib;
    rot_term_t   rt;
    logic [24:0] inv_p_b;

    // rounding
    logic signed [ACC_W-1:0] rnd_sum;
    logic signed [ACC_W-1:0] rs;
    logic signed [POS_W-1:0] res32;
    logic signed [Q_W-1:0]   res16;

    logic        in_acc;
    logic        out_free;
    logic        emit;
    logic [8:0]  n_wide;
    logic [CNT_W-1:0] n_eff;
    logic [CNT_W:0]   cnt_inc;

    function automatic logic signed [MAC_A_W-1:0] sx_a32(input logic signed [31:0] v);
        return {{(MAC_A_W-32){v[31]}}, v};
    endfunction

    function automatic logic signed [MAC_A_W-1:0] sx_a16(input logic signed [15:0] v);
        return {{(MAC_A_W-16){v[15]}}, v};
    endfunction

    function automatic logic signed [MAC_B_W-1:0] sx_b16(input logic signed [15:0] v);
        return {{(MAC_B_W-16){v[15]}}, v};
    endfunction

    // half-terms of the quaternion-to-matrix formula
    function automatic rot_term_t rot_term(input logic [3:0] e, input logic second);
        rot_term_t t;
        t = '{fa: QW, fb: QW, neg: 1'b0};
        case (e)
            4'd0: t = second ? '{QZ, QZ, 1'b1} : '{QY, QY, 1'b1};
            4'd1: t = second ? '{QZ, QW, 1'b1} : '{QX, QY, 1'b0};
            4'd2: t = second ? '{QY, QW, 1'b0} : '{QX, QZ, 1'b0};
            4'd3: t = second ? '{QZ, QW, 1'b0} : '{QX, QY, 1'b0};
            4'd4: t = second ? '{QZ, QZ, 1'b1} : '{QX, QX, 1'b1};
            4'd5: t = second ? '{QX, QW, 1'b1} : '{QY, QZ, 1'b0};
            4'd6: t = second ? '{QY, QW, 1'b1} : '{QX, QZ, 1'b0};
            4'd7: t = second ? '{QX, QW, 1'b0} : '{QY, QZ, 1'b0};
            4'd8: t = second ? '{QY, QY, 1'b1} : '{QX, QX, 1'b1};
            default: t = '{fa: QW, fb: QW, neg: 1'b0};
        endcase
        return t;
    endfunction

    assign in_acc       = sample.valid && sample.ready;
    assign sample.ready = (state_reg == S_IDLE);
    assign cfg.ready    = 1'b1;
    assign out_free     = !out_vld_reg || result.ready;
    assign emit         = (state_reg == S_DONE) && out_free;

    always_comb
    begin
        if (spo_reg == 8'd0)
            n_wide = 9'd1;
        else if ({1'b0, spo_reg} > 9'(MAX_SAMPLES))
            n_wide = 9'(MAX_SAMPLES);
        else
            n_wide = {1'b0, spo_reg};
        n_eff   = CNT_W'(n_wide);
        cnt_inc = {1'b0, cnt_reg} + (CNT_W+1)'(1);
    end

    // job index decode
    always_comb
    begin
        ax  = '0;
        ent = '0;
        case (job_reg) inside
            [J_EXT0:J_EXT2]:   ax  = 2'(job_reg - J_EXT0);
            [J_MEAN0:J_MEAN2]: ax  = 2'(job_reg - J_MEAN0);
            [J_ROT0:J_ROT8]:   ent = 4'(job_reg - J_ROT0);
            [J_VEL0:J_VEL2]:   ax  = 2'(job_reg - J_VEL0);
            [J_SKEW0:J_RATE2]: ax  = 2'((job_reg - J_SKEW0) >> 1);
            default: ;
        endcase
        case (ax)
            2'd0:    begin row_a = 2'd2; row_b = 2'd1; end
            2'd1:    begin row_a = 2'd0; row_b = 2'd2; end
            default: begin row_a = 2'd1; row_b = 2'd0; end
        endcase
        k  = op_idx_reg[2:1];
        ia = {2'b0, row_a} * 4'd3 + {2'b0, k};
        ib = {2'b0, row_b} * 4'd3 + {2'b0, k};
        rt = rot_term(ent, op_idx_reg[0]);
    end

    // operation decode
    always_comb
    begin
        mac_op       = '0;
        last_idx     = '0;
        rnd_sh       = 5'd24;
        inv_p_b      = {1'b0, inv_p_reg};
        mac_op.vld   = (state_reg == S_ISSUE);
        mac_op.first = (op_idx_reg == '0);
        case (job_reg) inside
            [J_EXT0:J_EXT2]:
            begin
                mac_op.a    = sx_a32(held_vel_reg[ax]);
                mac_op.b    = {1'b0, hold_reg};
                mac_op.init = {{(ACC_W-56){held_pos_reg[ax][31]}}, held_pos_reg[ax], 24'd0};
            end
            [J_MEAN0:J_MEAN2]:
            begin
                last_idx = 3'd1;
                rnd_sh   = 5'd16;
                mac_op.b = {8'd0, inv_s_reg};
                if (op_idx_reg[0])
                begin
                    mac_op.a  = {{(MAC_A_W-20){sum_reg[ax][39]}}, sum_reg[ax][39:20]};
                    mac_op.hi = 1'b1;
                end
                else
                    mac_op.a = {{(MAC_A_W-20){1'b0}}, sum_reg[ax][19:0]};
            end
            [J_ROT0:J_ROT8]:
            begin
                last_idx = 3'd1;
                rnd_sh   = 5'd13;
                mac_op.a = sx_a16(cur_q_reg[rt.fa]);
                mac_op.b = rt.neg ? -sx_b16(cur_q_reg[rt.fb]) : sx_b16(cur_q_reg[rt.fb]);
                if (ent == 4'd0 || ent == 4'd4 || ent == 4'd8)
                    mac_op.init = ROT_HALF;
            end
            [J_VEL0:J_VEL2]:
            begin
                last_idx = 3'd1;
                rnd_sh   = 5'd8;
                if (op_idx_reg[0])
                begin
                    mac_op.a = sx_a32(prev_mean_reg[ax]);
                    mac_op.b = -inv_p_b;
                end
                else
                begin
                    mac_op.a = sx_a32(mean_reg[ax]);
                    mac_op.b = inv_p_b;
                end
            end
            J_SKEW0, J_SKEW1, J_SKEW2:
            begin
                last_idx = 3'd5;
                mac_op.a = op_idx_reg[0] ? -sx_a16(prev_rot_reg[ia]) : sx_a16(rot_reg[ia]);
                mac_op.b = sx_b16(rot_reg[ib]);
            end
            J_RATE0, J_RATE1, J_RATE2:
            begin
                rnd_sh   = 5'd20;
                mac_op.a = skew_reg;
                mac_op.b = inv_p_b;
            end
            default: ;
        endcase
    end

    mpd_mac u_mac
    (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (mac_op),
        .acc   (acc)
    );

    // round half up, then saturate
    always_comb
    begin
        rnd_sum = acc + (ACC_W'(1) << (rnd_sh - 5'd1));
        rs      = rnd_sum >>> rnd_sh;
        if (rs > 64'sd2147483647)
            res32 = 32'sh7FFFFFFF;
        else if (rs < -64'sd2147483648)
            res32 = 32'sh80000000;
        else
            res32 = rs[31:0];
        if (rs > 64'sd32767)
            res16 = 16'sh7FFF;
        else if (rs < -64'sd32768)
            res16 = 16'sh8000;
        else
            res16 = rs[15:0];
    end

    // sequencer and held state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spo_reg        <= SPO_RST;
            inv_s_reg      <= INV_S_RST;
            inv_p_reg      <= INV_P_RST;
            hold_reg       <= HOLD_RST;
            state_reg      <= S_IDLE;
            job_reg        <= J_EXT0;
            op_idx_reg     <= '0;
            upd_reg        <= 1'b0;
            occ_reg        <= 1'b0;
            seen_reg       <= 1'b0;
            prev_stamp_reg <= '0;
            cnt_reg        <= '0;
            out_vld_reg    <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                held_pos_reg[i]  <= '0;
                held_vel_reg[i]  <= '0;
                held_rate_reg[i] <= '0;
                sum_reg[i]       <= '0;
                prev_mean_reg[i] <= '0;
            end
            held_q_reg[0] <= Q_ONE;
            for (int i = 1; i < 4; i++)
                held_q_reg[i] <= '0;
            for (int i = 0; i < 9; i++)
                prev_rot_reg[i] <= (i % 4 == 0) ? Q_ONE : '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg_reg_t'(cfg.index))
                    CFG_SAMPLES_PER_OUTPUT: spo_reg   <= cfg.data[7:0];
                    CFG_INV_SAMPLES:        inv_s_reg <= cfg.data[16:0];
                    CFG_INV_OUTPUT_PERIOD:  inv_p_reg <= cfg.data[23:0];
                    CFG_HOLD_STEP:          hold_reg  <= cfg.data[23:0];
                    default: ;
                endcase
            end

            if (result.valid && result.ready)
                out_vld_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        upd_reg        <= seen_reg && ({1'b0, sample.stamp_us} >
                                          {1'b0, prev_stamp_reg} + 64'd1);
                        prev_stamp_reg <= sample.stamp_us;
                        seen_reg       <= 1'b1;
                        occ_reg        <= sample.occluded;
                        op_idx_reg     <= '0;
                        job_reg        <= J_EXT0;
                        state_reg      <= sample.occluded ? S_ISSUE : S_MERGE;
                    end
                end
                S_ISSUE:
                begin
                    if (op_idx_reg == last_idx)
                        state_reg <= S_WAIT;
                    else
                        op_idx_reg <= op_idx_reg + 3'd1;
                end
                S_WAIT:
                    state_reg <= S_WRITE;
                S_WRITE:
                begin
                    op_idx_reg <= '0;
                    case (job_reg) inside
                        [J_VEL0:J_VEL2]:           held_vel_reg[ax]  <= res32;
                        J_RATE0, J_RATE1, J_RATE2: held_rate_reg[ax] <= res32;
                        default: ;
                    endcase
                    case (job_reg)
                        J_EXT2:  state_reg <= S_MERGE;
                        J_ROT8:
                        begin
                            if (upd_reg)
                            begin
                                job_reg   <= J_VEL0;
                                state_reg <= S_ISSUE;
                            end
                            else
                                state_reg <= S_DONE;
                        end
                        J_RATE2: state_reg <= S_DONE;
                        default:
                        begin
                            job_reg   <= job_t'(job_reg + 5'd1);
                            state_reg <= S_ISSUE;
                        end
                    endcase
                end
                S_MERGE:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        held_pos_reg[i] <= cur_pos_reg[i];
                        sum_reg[i]      <= sum_reg[i] +
                                           {{8{cur_pos_reg[i][31]}}, cur_pos_reg[i]};
                    end
                    for (int i = 0; i < 4; i++)
                        held_q_reg[i] <= cur_q_reg[i];
                    if (cnt_inc >= {1'b0, n_eff})
                    begin
                        cnt_reg    <= '0;
                        job_reg    <= J_MEAN0;
                        op_idx_reg <= '0;
                        state_reg  <= S_ISSUE;
                    end
                    else
                    begin
                        cnt_reg   <= cnt_inc[CNT_W-1:0];
                        state_reg <= S_IDLE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            prev_mean_reg[i] <= mean_reg[i];
                            sum_reg[i]       <= '0;
                        end
                        for (int i = 0; i < 9; i++)
                            prev_rot_reg[i] <= rot_reg[i];
                        out_vld_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // working and output payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cur_pos_reg[0] <= sample.pos_x;
            cur_pos_reg[1] <= sample.pos_y;
            cur_pos_reg[2] <= sample.pos_z;
            cur_q_reg[0]   <= sample.occluded ? held_q_reg[0] : sample.quat_w;
            cur_q_reg[1]   <= sample.occluded ? held_q_reg[1] : sample.quat_x;
            cur_q_reg[2]   <= sample.occluded ? held_q_reg[2] : sample.quat_y;
            cur_q_reg[3]   <= sample.occluded ? held_q_reg[3] : sample.quat_z;
            stamp_reg      <= sample.stamp_us;
            seq_reg        <= sample.sequence_req;
        end
        if (state_reg == S_WRITE)
        begin
            case (job_reg) inside
                [J_EXT0:J_EXT2]:           cur_pos_reg[ax] <= res32;
                [J_MEAN0:J_MEAN2]:         mean_reg[ax]    <= res32;
                [J_ROT0:J_ROT8]:           rot_reg[ent]    <= res16;
                J_SKEW0, J_SKEW1, J_SKEW2: skew_reg        <= acc[MAC_A_W-1:0];
                default: ;
            endcase
        end
        if (emit)
        begin
            o_seq_reg   <= seq_reg;
            o_stamp_reg <= stamp_reg;
            o_quat_reg  <= {cur_q_reg[0], cur_q_reg[1], cur_q_reg[2], cur_q_reg[3]};
            for (int i = 0; i < 3; i++)
            begin
                o_avg_reg[i]  <= mean_reg[i];
                o_vel_reg[i]  <= held_vel_reg[i];
                o_rate_reg[i] <= held_rate_reg[i];
            end
        end
    end

    assign result.valid        = out_vld_reg;
    assign result.out_sequence = o_seq_reg;
    assign result.out_stamp_us = o_stamp_reg;
    assign result.avg_x        = o_avg_reg[0];
    assign result.avg_y        = o_avg_reg[1];
    assign result.avg_z        = o_avg_reg[2];
    assign result.orientation  = o_quat_reg;
    assign result.vel_x        = o_vel_reg[0];
    assign result.vel_y        = o_vel_reg[1];
    assign result.vel_z        = o_vel_reg[2];
    assign result.rate_x       = o_rate_reg[0];
    assign result.rate_y       = o_rate_reg[1];
    assign result.rate_z       = o_rate_reg[2];

    `MPD_ASSERT_NEXT(a_busy_after_beat, sample.valid && sample.ready, !sample.ready, "ready after sample beat")
    `MPD_ASSERT_NEXT(a_no_overwrite, state_reg == S_DONE && out_vld_reg && !result.ready, state_reg == S_DONE && out_vld_reg, "pending result overwritten")
    `MPD_ASSERT_IMPL(a_result_source, $rose(result.valid), $past(state_reg) == S_DONE, "result raised outside done")

endmodule

`default_nettype wire
